/* sv/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition must never be seen
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

`endif

/* sv/wmvs_pkg.sv */
package wmvs_pkg;

   // input transaction
   typedef struct packed {
      logic signed [15:0] target_sample;
      logic [11:0]        sample_weight;
      logic               in_training;
      logic               last_sample;
   } req_type;

   // result transaction
   typedef struct packed {
      logic signed [15:0] mean_value;
      logic [31:0]        variance_value;
      logic [15:0]        std_deviation;
      logic [1:0]         status;
   } rsp_type;

   // front to top status
   typedef struct packed {
      logic       push;
      logic [1:0] pending_last;
   } front_stat_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
   localparam logic [1:0] STATUS_ZERO_SUM = 2'd2;

   localparam int QUEUE_DEPTH = 2;

endpackage

/* sv/wmvs_queue.sv */
module wmvs_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty,
   output logic [1:0]       count
);
   import wmvs_pkg::*;

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

   assign data_out = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == 2'd0);
   assign count    = count_ff;

endmodule

/* sv/wmvs_front.sv */
module wmvs_front #(
   parameter int MAX_SAMPLES = 1024,
   parameter int CW = 11,
   parameter int WW = 23,
   parameter int SW = 39,
   parameter int QW = 53
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  wmvs_pkg::req_type       req_item,
   input  logic                    csr_write,
   input  logic                    csr_data,
   output wmvs_pkg::front_stat_type stat,
   output logic                    job_mode,
   output logic [CW-1:0]           job_count,
   output logic [WW-1:0]           job_wsum,
   output logic signed [SW-1:0]    job_sum,
   output logic [QW-1:0]           job_sqsum
);
   import wmvs_pkg::*;

   logic                accept, take;
   logic                mode_ff, mode_in;
   logic [CW-1:0]       cnt_ff, cnt_in, cnt_final;

   // stage one: effective weight and sample
   logic                v1_ff, l1_ff, m1_ff;
   logic [11:0]         ew1_ff;
   logic signed [15:0]  t1_ff;
   logic [CW-1:0]       n1_ff;

   // stage two: first products
   logic                v2_ff, l2_ff, m2_ff;
   logic [11:0]         ew2_ff;
   logic signed [28:0]  wt2_ff;
   logic [30:0]         tt2_ff;
   logic [CW-1:0]       n2_ff;

   logic signed [31:0]  tt_full;
   logic signed [28:0]  wt_full;
   logic [42:0]         wtt;

   logic [WW-1:0]        wacc_ff, wacc_in, wsum_nx;
   logic signed [SW-1:0] sacc_ff, sacc_in, ssum_nx;
   logic [QW-1:0]        qacc_ff, qacc_in, qsum_nx;

   // accept and sample count
   always_comb begin
      accept    = start && !busy;
      take      = accept && req_item.in_training && (cnt_ff < CW'(MAX_SAMPLES));
      cnt_final = cnt_ff + CW'(take);
      cnt_in    = cnt_ff;
      if (accept) begin
         cnt_in = req_item.last_sample ? '0 : cnt_final;
      end
      mode_in = csr_write ? csr_data : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         mode_ff <= 1'b0;
         v1_ff   <= 1'b0;
         l1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         l2_ff   <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         mode_ff <= mode_in;
         v1_ff   <= take;
         l1_ff   <= accept && req_item.last_sample;
         v2_ff   <= v1_ff;
         l2_ff   <= l1_ff;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      ew1_ff <= mode_ff ? req_item.sample_weight : 12'd1;
      t1_ff  <= req_item.target_sample;
      n1_ff  <= cnt_final;
      m1_ff  <= mode_ff;
   end

   // stage two products
   always_comb begin
      wt_full = 29'($signed({1'b0, ew1_ff}) * t1_ff);
      tt_full = t1_ff * t1_ff;
   end

   always_ff @(posedge clock) begin
      ew2_ff <= ew1_ff;
      wt2_ff <= wt_full;
      tt2_ff <= tt_full[30:0];
      n2_ff  <= n1_ff;
      m2_ff  <= m1_ff;
   end

   // accumulate, snapshot and clear on the last sample
   always_comb begin
      wtt     = ew2_ff * tt2_ff;
      wsum_nx = wacc_ff;
      ssum_nx = sacc_ff;
      qsum_nx = qacc_ff;
      if (v2_ff) begin
         wsum_nx = wacc_ff + WW'(ew2_ff);
         ssum_nx = sacc_ff + {{(SW-29){wt2_ff[28]}}, wt2_ff};
         qsum_nx = qacc_ff + QW'(wtt);
      end
      wacc_in = l2_ff ? '0 : wsum_nx;
      sacc_in = l2_ff ? '0 : ssum_nx;
      qacc_in = l2_ff ? '0 : qsum_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wacc_ff <= '0;
         sacc_ff <= '0;
         qacc_ff <= '0;
      end else begin
         wacc_ff <= wacc_in;
         sacc_ff <= sacc_in;
         qacc_ff <= qacc_in;
      end
   end

   assign job_mode          = m2_ff;
   assign job_count         = n2_ff;
   assign job_wsum          = wsum_nx;
   assign job_sum           = ssum_nx;
   assign job_sqsum         = qsum_nx;
   assign stat.push         = l2_ff;
   assign stat.pending_last = {1'b0, l1_ff} + {1'b0, l2_ff};

endmodule

/* sv/wmvs_back.sv */
module wmvs_back #(
   parameter int CW = 11,
   parameter int WW = 23,
   parameter int SW = 39,
   parameter int QW = 53
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   input  logic                 job_mode,
   input  logic [CW-1:0]        job_count,
   input  logic [WW-1:0]        job_wsum,
   input  logic signed [SW-1:0] job_sum,
   input  logic [QW-1:0]        job_sqsum,
   output logic                 pop,
   output logic                 rsp_valid,
   output wmvs_pkg::rsp_type    rsp_item
);
   import wmvs_pkg::*;

   localparam int MW  = SW - 1;
   localparam int PW  = WW + QW;
   localparam int DW  = 2 * WW;
   localparam int CTW = $clog2(PW);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MUL_AQ   = 3'd1;
   localparam logic [2:0] ST_MUL_SS   = 3'd2;
   localparam logic [2:0] ST_MUL_D    = 3'd3;
   localparam logic [2:0] ST_DIV_MEAN = 3'd4;
   localparam logic [2:0] ST_DIV_VAR  = 3'd5;
   localparam logic [2:0] ST_SQRT     = 3'd6;

   logic [2:0]      state_ff, state_in;
   logic [CTW-1:0]  cnt_ff, cnt_in;
   logic            mode_ff, mode_in, neg_ff, neg_in;
   logic [CW-1:0]   n_ff, n_in;
   logic [WW-1:0]   a_ff, a_in;
   logic [MW-1:0]   mag_ff, mag_in, mag_job;
   logic [QW-1:0]   q_ff, q_in;
   logic [PW-1:0]   aq_ff, aq_in;
   logic [DW-1:0]   d_ff, d_in;
   // shift-add multiplier
   logic [PW-1:0]   mc_ff, mc_in, pr_ff, pr_in, pr_nx;
   logic [MW-1:0]   mp_ff, mp_in;
   // restoring divider
   logic [PW-1:0]   nm_ff, nm_in, qo_ff, qo_in, qo_nx;
   logic [DW-1:0]   dv_ff, dv_in;
   logic [DW:0]     rm_ff, rm_in, rm_nx, rm_sh;
   logic            qbit, rnd;
   logic [PW:0]     qr;
   // square root
   logic [31:0]     x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic [32:0]     trial;
   // result
   logic            valid_ff, valid_in;
   rsp_type         rsp_ff, rsp_in;
   logic [1:0]      st_job;
   logic [16:0]     qmc;
   logic            mul_last, div_last, sqrt_last;

   // datapath step values
   always_comb begin
      pr_nx     = mp_ff[0] ? pr_ff + mc_ff : pr_ff;
      rm_sh     = {rm_ff[DW-1:0], nm_ff[PW-1]};
      qbit      = (rm_sh >= {1'b0, dv_ff});
      rm_nx     = qbit ? rm_sh - {1'b0, dv_ff} : rm_sh;
      qo_nx     = {qo_ff[PW-2:0], qbit};
      rnd       = ({rm_nx, 1'b0} >= {2'b00, dv_ff});
      qr        = {1'b0, qo_nx} + (PW+1)'(rnd);
      trial     = {1'b0, res_ff} + {1'b0, bit_ff};
      mul_last  = (cnt_ff == CTW'(MW - 1));
      div_last  = (cnt_ff == CTW'(PW - 1));
      sqrt_last = (cnt_ff == CTW'(15));
      mag_job   = job_sum[SW-1] ? MW'(-job_sum) : MW'(job_sum);
      if (job_count < CW'(2)) begin
         st_job = STATUS_TOO_FEW;
      end else if (job_mode && job_wsum == '0) begin
         st_job = STATUS_ZERO_SUM;
      end else begin
         st_job = STATUS_OK;
      end
      if (qr > (PW+1)'(32768)) begin
         qmc = 17'd32768;
      end else begin
         qmc = qr[16:0];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + CTW'(1);
      mode_in  = mode_ff;
      neg_in   = neg_ff;
      n_in     = n_ff;
      a_in     = a_ff;
      mag_in   = mag_ff;
      q_in     = q_ff;
      aq_in    = aq_ff;
      d_in     = d_ff;
      mc_in    = mc_ff << 1;
      mp_in    = mp_ff >> 1;
      pr_in    = pr_nx;
      nm_in    = nm_ff << 1;
      dv_in    = dv_ff;
      rm_in    = rm_nx;
      qo_in    = qo_nx;
      x_in     = x_ff;
      res_in   = res_ff;
      bit_in   = bit_ff >> 2;
      valid_in = 1'b0;
      rsp_in   = rsp_ff;
      pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (!empty) begin
               pop     = 1'b1;
               mode_in = job_mode;
               neg_in  = job_sum[SW-1];
               n_in    = job_count;
               a_in    = job_mode ? job_wsum : WW'(job_count);
               mag_in  = mag_job;
               q_in    = job_sqsum;
               mc_in   = PW'(job_sqsum);
               mp_in   = job_mode ? MW'(job_wsum) : MW'(job_count);
               pr_in   = '0;
               if (st_job != STATUS_OK) begin
                  valid_in = 1'b1;
                  rsp_in   = '0;
                  rsp_in.status = st_job;
               end else begin
                  state_in = ST_MUL_AQ;
               end
            end
         end
         ST_MUL_AQ: begin
            if (mul_last) begin
               aq_in    = pr_nx;
               mc_in    = PW'(mag_ff);
               mp_in    = mag_ff;
               pr_in    = '0;
               cnt_in   = '0;
               state_in = ST_MUL_SS;
            end
         end
         ST_MUL_SS: begin
            if (mul_last) begin
               aq_in    = (aq_ff >= pr_nx) ? aq_ff - pr_nx : '0;
               mc_in    = mode_ff ? PW'(a_ff) : PW'(n_ff);
               mp_in    = mode_ff ? MW'(a_ff) : MW'(n_ff - CW'(1));
               pr_in    = '0;
               cnt_in   = '0;
               state_in = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            if (mul_last) begin
               d_in     = pr_nx[DW-1:0];
               nm_in    = PW'(mag_ff);
               dv_in    = DW'(a_ff);
               rm_in    = '0;
               qo_in    = '0;
               cnt_in   = '0;
               state_in = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            if (div_last) begin
               if (neg_ff) begin
                  rsp_in.mean_value = 16'(17'd0 - qmc);
               end else if (qmc > 17'd32767) begin
                  rsp_in.mean_value = 16'sd32767;
               end else begin
                  rsp_in.mean_value = qmc[15:0];
               end
               nm_in    = aq_ff;
               dv_in    = d_ff;
               rm_in    = '0;
               qo_in    = '0;
               cnt_in   = '0;
               state_in = ST_DIV_VAR;
            end
         end
         ST_DIV_VAR: begin
            if (div_last) begin
               x_in     = (qr[PW:32] != '0) ? 32'hFFFF_FFFF : qr[31:0];
               rsp_in.variance_value = x_in;
               res_in   = '0;
               bit_in   = 32'h4000_0000;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if ({1'b0, x_ff} >= trial) begin
               x_in   = x_ff - trial[31:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            if (sqrt_last) begin
               rsp_in.std_deviation = res_in[15:0];
               rsp_in.status        = STATUS_OK;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      mode_ff <= mode_in;
      neg_ff  <= neg_in;
      n_ff    <= n_in;
      a_ff    <= a_in;
      mag_ff  <= mag_in;
      q_ff    <= q_in;
      aq_ff   <= aq_in;
      d_ff    <= d_in;
      mc_ff   <= mc_in;
      mp_ff   <= mp_in;
      pr_ff   <= pr_in;
      nm_ff   <= nm_in;
      dv_ff   <= dv_in;
      rm_ff   <= rm_in;
      qo_ff   <= qo_in;
      x_ff    <= x_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* sv/weighted_mean_variance_std.sv */
// Weighted or plain mean, variance and standard deviation of a sample set.
// Samples are taken one per cycle while busy is low; the accumulating front
// end is a three-stage pipeline. The last sample of a set hands a snapshot
// of the sums to a two-entry queue, and the finishing unit works it out with
// a shift-add multiplier (three products), a restoring divider (two
// divisions) and a 16-step square root. Sets with an error status finish
// at once. busy rises while the queued sets plus the last samples still in
// the front end pipeline reach the two queue entries.
// Each result is shown on rsp_item for exactly one cycle with rsp_valid
// high; the receiver cannot stall it and must take it then.
`include "assert_macros.svh"

module weighted_mean_variance_std #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  wmvs_pkg::req_type req_item,
   output logic              rsp_valid,
   output wmvs_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import wmvs_pkg::*;

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int WW = CW + 12;
   localparam int SW = WW + 16;
   localparam int QW = WW + 30;
   localparam int JW = 1 + CW + WW + SW + QW;

   front_stat_type       stat;
   logic                 job_mode;
   logic [CW-1:0]        job_count;
   logic [WW-1:0]        job_wsum;
   logic signed [SW-1:0] job_sum;
   logic [QW-1:0]        job_sqsum;
   logic [JW-1:0]        q_in, q_out;
   logic                 q_empty, q_pop;
   logic [1:0]           q_count;
   logic [2:0]           q_load;

   // hold off input when no queue room remains for lasts in flight
   assign q_load    = {1'b0, q_count} + {1'b0, stat.pending_last};
   assign busy      = (q_load >= 3'(QUEUE_DEPTH));
   assign csr_ready = 1'b1;

   wmvs_front #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .CW(CW), .WW(WW), .SW(SW), .QW(QW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .stat      (stat),
      .job_mode  (job_mode),
      .job_count (job_count),
      .job_wsum  (job_wsum),
      .job_sum   (job_sum),
      .job_sqsum (job_sqsum)
   );

   assign q_in = {job_mode, job_count, job_wsum, job_sum, job_sqsum};

   wmvs_queue #(
      .WIDTH(JW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (stat.push),
      .data_in  (q_in),
      .pop      (q_pop),
      .data_out (q_out),
      .empty    (q_empty),
      .count    (q_count)
   );

   wmvs_back #(
      .CW(CW), .WW(WW), .SW(SW), .QW(QW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (q_empty),
      .job_mode  (q_out[JW-1]),
      .job_count (q_out[JW-2 -: CW]),
      .job_wsum  (q_out[JW-2-CW -: WW]),
      .job_sum   ($signed(q_out[QW+SW-1 -: SW])),
      .job_sqsum (q_out[QW-1:0]),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // checks
   `ASSERT_NEVER(a_queue_overflow, clock, reset,
      stat.push && q_count == 2'(QUEUE_DEPTH) && !q_pop)
   `ASSERT_IMPLY(a_error_zero, clock, reset,
      rsp_valid && rsp_item.status != STATUS_OK,
      rsp_item.mean_value == '0 && rsp_item.variance_value == '0 &&
      rsp_item.std_deviation == '0)
   `ASSERT_IMPLY(a_root_bound, clock, reset, rsp_valid,
      32'(rsp_item.std_deviation) * 32'(rsp_item.std_deviation)
         <= rsp_item.variance_value)

endmodule

/* tb/tb_weighted_mean_variance_std.sv */
`timescale 1ns / 1ps

module tb_weighted_mean_variance_std;
   import wmvs_pkg::*;

   localparam int SET_LIMIT = 1024;
   localparam int SETTLE_CYCLES = 300;
   localparam int TOTAL_ITEMS = 1400;
   localparam int CALM_TAIL = 100;
   localparam logic [1:0] MODE_KEEP = 2'd2;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;

   // predictor state
   bit                 weight_mode;
   logic [10:0]        n_acc;
   logic [21:0]        w_acc;
   logic signed [37:0] s_acc;
   logic [53:0]        q_acc;

   rsp_type pending_stats[$];
   int      fail_count = 0;
   int      items_sent = 0;
   bit      gaps_on = 1'b1;

   // directed stimulus row
   typedef struct {
      logic [1:0] mode_write;
      req_type    item;
      bit         fixed;
      rsp_type    stats;
   } row_type;

   row_type rows[$];

   weighted_mean_variance_std dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // watchdog
   initial begin
      #30ms;
      $display("weighted_mean_variance_std: mismatch");
      $finish;
   end

   function automatic req_type mk(int t, int w, bit tr, bit lst);
      req_type r;
      r.target_sample = t[15:0];
      r.sample_weight = w[11:0];
      r.in_training = tr;
      r.last_sample = lst;
      return r;
   endfunction

   // accumulate one sample, compute statistics on the last one
   function automatic bit accumulate_and_finish(req_type r, output rsp_type res);
      longint       tl, ew, sl;
      logic [127:0] a, d, mag, qm, num, aq, ss, qv, rem;
      logic [31:0]  var32;
      logic [16:0]  root;
      longint       mean;
      res = '0;
      tl = longint'(r.target_sample);
      ew = weight_mode ? longint'(r.sample_weight) : 1;
      if (r.in_training && n_acc < SET_LIMIT) begin
         n_acc = n_acc + 11'd1;
         w_acc = w_acc + 22'(ew);
         s_acc = s_acc + 38'(ew * tl);
         q_acc = q_acc + 54'(ew * tl * tl);
      end
      if (!r.last_sample) return 1'b0;
      if (n_acc < 2) begin
         res.status = STATUS_TOO_FEW;
      end else if (weight_mode && w_acc == 0) begin
         res.status = STATUS_ZERO_SUM;
      end else begin
         res.status = STATUS_OK;
         a = weight_mode ? 128'(w_acc) : 128'(n_acc);
         d = weight_mode ? 128'(w_acc) * 128'(w_acc) : 128'(n_acc) * 128'(n_acc - 1);
         sl = longint'(s_acc);
         mag = sl < 0 ? 128'(-sl) : 128'(sl);
         qm = (2 * mag + a) / (2 * a);
         if (qm > 32768) qm = 32768;
         mean = sl < 0 ? -longint'(qm) : longint'(qm);
         if (mean > 32767) mean = 32767;
         res.mean_value = mean[15:0];
         aq = a * 128'(q_acc);
         ss = mag * mag;
         num = (aq < ss) ? 128'd0 : aq - ss;
         qv = num / d;
         rem = num % d;
         if (rem >= d - rem) qv = qv + 1;
         var32 = (qv > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : qv[31:0];
         res.variance_value = var32;
         // floor square root, one bit at a time
         root = '0;
         for (int b = 15; b >= 0; b--) begin
            if (64'(root | (17'd1 << b)) * 64'(root | (17'd1 << b)) <= 64'(var32))
               root = root | (17'd1 << b);
         end
         res.std_deviation = root[15:0];
      end
      n_acc = '0;
      w_acc = '0;
      s_acc = '0;
      q_acc = '0;
      return 1'b1;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_stats.size() == 0) begin
            $error("unexpected result transaction");
            fail_count++;
         end else begin
            want = pending_stats.pop_front();
            if (rsp_item.mean_value !== want.mean_value) begin
               $error("mean_value expected %0d got %0d", want.mean_value,
                      rsp_item.mean_value);
               fail_count++;
            end
            if (rsp_item.variance_value !== want.variance_value) begin
               $error("variance_value expected %0d got %0d", want.variance_value,
                      rsp_item.variance_value);
               fail_count++;
            end
            if (rsp_item.std_deviation !== want.std_deviation) begin
               $error("std_deviation expected %0d got %0d", want.std_deviation,
                      rsp_item.std_deviation);
               fail_count++;
            end
            if (rsp_item.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_item.status);
               fail_count++;
            end
         end
      end
   end

   // wait until no result is outstanding and the pipeline has drained
   task automatic settle();
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(bit m);
      csr_valid <= 1'b1;
      csr_data <= m;
      do @(posedge clock); while (!csr_ready);
      weight_mode = m;
      csr_valid <= 1'b0;
      csr_data <= 1'($urandom_range(0, 1));
   endtask

   // send one transaction, optionally with a known result
   task automatic send(req_type r, bit fixed, rsp_type fixed_stats);
      rsp_type res;
      bit      has;
      int      gap;
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      has = accumulate_and_finish(r, res);
      if (has) pending_stats.push_back(fixed ? fixed_stats : res);
      items_sent++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         start <= 1'b0;
         req_item <= req_type'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int rand_target();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32767 : -32768;
         1: return int'($urandom_range(0, 512)) - 256;
         2: return int'($urandom_range(0, 8191)) - 4096;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   function automatic int rand_weight();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 4095;
         2: return $urandom_range(0, 15);
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   task automatic add_row(logic [1:0] m, req_type r, bit fx, rsp_type s);
      row_type x;
      x.mode_write = m;
      x.item = r;
      x.fixed = fx;
      x.stats = s;
      rows.push_back(x);
   endtask

   initial begin
      rsp_type z, too_few, zero_sum;
      int      set_len;
      int      since_cfg;
      z = '0;
      too_few = '0;
      too_few.status = STATUS_TOO_FEW;
      zero_sum = '0;
      zero_sum.status = STATUS_ZERO_SUM;
      weight_mode = 1'b0;
      n_acc = '0;
      w_acc = '0;
      s_acc = '0;
      q_acc = '0;

      // directed table
      add_row(MODE_KEEP, mk(256, 5, 1, 1), 1, too_few);
      add_row(MODE_KEEP, mk(77, 9, 0, 1), 1, too_few);
      add_row(MODE_KEEP, mk(0, 0, 1, 0), 0, z);
      add_row(MODE_KEEP, mk(0, 4095, 1, 1), 1, z);
      add_row(MODE_KEEP, mk(32767, 4095, 1, 0), 0, z);
      add_row(MODE_KEEP, mk(-32768, 0, 1, 1), 0, z);
      add_row(MODE_KEEP, mk(1000, 3, 0, 0), 0, z);
      add_row(MODE_KEEP, mk(256, 3, 1, 0), 0, z);
      add_row(MODE_KEEP, mk(512, 3, 1, 1), 0, z);
      add_row(2'd1, mk(100, 0, 1, 0), 0, z);
      add_row(MODE_KEEP, mk(200, 0, 1, 1), 1, zero_sum);
      add_row(MODE_KEEP, mk(32767, 4095, 1, 0), 0, z);
      add_row(MODE_KEEP, mk(-32768, 4095, 1, 0), 0, z);
      add_row(MODE_KEEP, mk(256, 1, 1, 1), 0, z);
      add_row(MODE_KEEP, mk(-300, 0, 1, 0), 0, z);
      add_row(MODE_KEEP, mk(640, 10, 1, 1), 0, z);
      add_row(2'd0, mk(300, 12, 1, 0), 0, z);
      add_row(2'd1, mk(500, 7, 1, 1), 0, z);
      add_row(2'd0, mk(-1, 1, 1, 0), 0, z);
      add_row(MODE_KEEP, mk(-1, 1, 0, 1), 1, too_few);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].mode_write != MODE_KEEP) begin
            start <= 1'b0;
            settle();
            write_mode(rows[i].mode_write[0]);
         end
         send(rows[i].item, rows[i].fixed, rows[i].stats);
      end

      // overlong set: samples past the limit are dropped
      start <= 1'b0;
      settle();
      write_mode(1'b0);
      for (int i = 0; i < SET_LIMIT + 6; i++)
         send(mk(rand_target(), 0, 1, i == SET_LIMIT + 5), 0, z);

      // random sets
      since_cfg = 0;
      while (items_sent < TOTAL_ITEMS) begin
         if (since_cfg > 100) begin
            start <= 1'b0;
            settle();
            write_mode(1'($urandom_range(0, 1)));
            since_cfg = 0;
         end
         if (items_sent > TOTAL_ITEMS - CALM_TAIL) gaps_on = 1'b0;
         set_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 30);
         for (int k = 0; k < set_len; k++) begin
            send(mk(rand_target(), rand_weight(), $urandom_range(0, 9) != 0,
                    k == set_len - 1), 0, z);
            since_cfg++;
         end
         // occasional noise: stray masked samples
         if ($urandom_range(0, 7) == 0)
            send(mk(rand_target(), rand_weight(), 0, 0), 0, z);
      end

      start <= 1'b0;
      settle();
      if (fail_count == 0) begin
         $display("weighted_mean_variance_std: match");
      end else begin
         $display("weighted_mean_variance_std: mismatch");
      end
      $finish;
   end

endmodule
